// ===== src/stk_pkg.sv =====
// Shared types, widths and constants for the stick channel conditioner.
// No dependencies; imported by every module of the block.
package stk_pkg;

    localparam int CHANNELS   = 4;
    localparam int SAMPLE_W   = 12;
    localparam int OFFSET_W   = 10;
    localparam int MAP_W      = 12;
    localparam int VALUE_W    = 11;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam int DEFAULT_WINDOW_LENGTH = 10;

    // channel slots, also the register index of each offset
    localparam int CH_THROTTLE = 0;
    localparam int CH_PITCH    = 1;
    localparam int CH_ROLL     = 2;
    localparam int CH_YAW      = 3;

    localparam int MAP_BASE = 1000;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 12'd4095;
    localparam logic [VALUE_W-1:0]  OUT_LOW        = 11'd1000;
    localparam logic [VALUE_W-1:0]  OUT_HIGH       = 11'd2000;
    localparam logic [VALUE_W-1:0]  CENTER         = 11'd1500;
    localparam logic [VALUE_W-1:0]  THR_BAND_LOW   = 11'd1450;
    localparam logic [VALUE_W-1:0]  THR_BAND_HIGH  = 11'd1550;
    localparam logic [VALUE_W-1:0]  AXIS_BAND_LOW  = 11'd1490;
    localparam logic [VALUE_W-1:0]  AXIS_BAND_HIGH = 11'd1510;

    // one mapped sample per channel, as held by a window cell
    typedef logic [CHANNELS-1:0][MAP_W-1:0] t_quad;

    // per-stage load strobes from the top-level flow control
    typedef struct packed {
        logic load_sum;
        logic load_prod;
        logic load_out;
    } t_lane_ctl;

endpackage

// ===== src/stick_channel_conditioner.sv =====
// Top level of the stick channel conditioner: window cell chain, four
// channel lanes, flow control and offset registers. Depends on stk_pkg,
// stk_cell and stk_lane.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat of four raw
//   12-bit samples: throttle, pitch, roll, yaw. Output channel
//   (o_out_valid / i_out_ready) returns one beat of four 11-bit values in
//   1000..2000 for every input beat, in order.
//   Offsets are written over the APB-style port: throttle at 0x0, pitch
//   at 0x4, roll at 0x8, yaw at 0xC, 10-bit two's complement in pwdata.
//   Write them only while no beat is in flight.
//
// A beat passes three registered stages in order: running sum update,
// reciprocal multiply, clamp/snap into the output register. Throughput
// is one beat per cycle when not stalled; each stage holds its beat only
// when the next one is full and stalled, so input keeps flowing into
// empty stages while a result waits at the output. o_in_ready drops
// only when all three stages are full and the receiver stalls.
//
// Reset (synchronous, active low) clears the window cells, running sums,
// offsets and stage valids. The window starts at zero, so the first
// WINDOW_LENGTH-1 or so outputs ramp up from the 1000 floor.
module stick_channel_conditioner import stk_pkg::*; #(
    parameter int WINDOW_LENGTH = DEFAULT_WINDOW_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // input beats
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_throttle_sample,
    input  logic [SAMPLE_W-1:0] i_pitch_sample,
    input  logic [SAMPLE_W-1:0] i_roll_sample,
    input  logic [SAMPLE_W-1:0] i_yaw_sample,
    // output beats
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [VALUE_W-1:0]  o_throttle_value,
    output logic [VALUE_W-1:0]  o_pitch_value,
    output logic [VALUE_W-1:0]  o_roll_value,
    output logic [VALUE_W-1:0]  o_yaw_value
);

    logic [OFFSET_W-1:0] r_offset [CHANNELS];
    logic [1:0]          w_reg_idx;
    logic                w_cfg_wr;

    logic      r_v_sum, r_v_prod, r_v_out;
    logic      w_rdy_sum, w_rdy_prod, w_rdy_out;
    t_lane_ctl w_ctl;

    logic [SAMPLE_W-1:0] w_sample   [CHANNELS];
    logic [VALUE_W-1:0]  w_band_lo  [CHANNELS];
    logic [VALUE_W-1:0]  w_band_hi  [CHANNELS];
    logic [VALUE_W-1:0]  w_value    [CHANNELS];
    t_quad               w_mapped;
    t_quad               w_oldest;
    t_quad               w_cell_out [WINDOW_LENGTH];

    // ---------------- config registers ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_offset[k] <= '0;
            end
        end else if (w_cfg_wr) begin
            r_offset[w_reg_idx] <= pwdata[OFFSET_W-1:0];
        end
    end

    // read back sign extended
    assign prdata = {{(DATA_W-OFFSET_W){r_offset[w_reg_idx][OFFSET_W-1]}},
                     r_offset[w_reg_idx]};

    // ---------------- flow control ----------------
    // a stage takes a new beat when it is empty or its beat moves on
    assign w_rdy_out  = !r_v_out  || i_out_ready;
    assign w_rdy_prod = !r_v_prod || w_rdy_out;
    assign w_rdy_sum  = !r_v_sum  || w_rdy_prod;

    assign o_in_ready  = w_rdy_sum;
    assign o_out_valid = r_v_out;

    assign w_ctl.load_sum  = i_in_valid & w_rdy_sum;
    assign w_ctl.load_prod = r_v_sum    & w_rdy_prod;
    assign w_ctl.load_out  = r_v_prod   & w_rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sum  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (w_rdy_sum) begin
                r_v_sum <= i_in_valid;
            end
            if (w_rdy_prod) begin
                r_v_prod <= r_v_sum;
            end
            if (w_rdy_out) begin
                r_v_out <= r_v_prod;
            end
        end
    end

    // ---------------- channel lanes ----------------
    // throttle is inverted before mapping
    assign w_sample[CH_THROTTLE] = SAMPLE_MAX - i_throttle_sample;
    assign w_sample[CH_PITCH]    = i_pitch_sample;
    assign w_sample[CH_ROLL]     = i_roll_sample;
    assign w_sample[CH_YAW]      = i_yaw_sample;

    // oldest window entry leaves from the last cell
    assign w_oldest = w_cell_out[WINDOW_LENGTH-1];

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        assign w_band_lo[ch] = (ch == CH_THROTTLE) ? THR_BAND_LOW  : AXIS_BAND_LOW;
        assign w_band_hi[ch] = (ch == CH_THROTTLE) ? THR_BAND_HIGH : AXIS_BAND_HIGH;

        stk_lane #(
            .WINDOW_LENGTH (WINDOW_LENGTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_sample  (w_sample[ch]),
            .i_offset  (r_offset[ch]),
            .i_oldest  (w_oldest[ch]),
            .i_band_lo (w_band_lo[ch]),
            .i_band_hi (w_band_hi[ch]),
            .o_mapped  (w_mapped[ch]),
            .o_value   (w_value[ch])
        );
    end

    // ---------------- window cell chain ----------------
    // newest sample enters cell 0; every accepted beat moves all cells on
    for (genvar c = 0; c < WINDOW_LENGTH; c++) begin : g_cell
        t_quad w_cell_in;
        if (c == 0) begin : g_head
            assign w_cell_in = w_mapped;
        end else begin : g_body
            assign w_cell_in = w_cell_out[c-1];
        end

        stk_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_ctl.load_sum),
            .i_data  (w_cell_in),
            .o_data  (w_cell_out[c])
        );
    end

    assign o_throttle_value = w_value[CH_THROTTLE];
    assign o_pitch_value    = w_value[CH_PITCH];
    assign o_roll_value     = w_value[CH_ROLL];
    assign o_yaw_value      = w_value[CH_YAW];

endmodule

// ===== src/stk_cell.sv =====
// One window cell: holds one mapped sample of every channel.
// Depends on stk_pkg; chained in the top level to form the averaging window.
module stk_cell import stk_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_quad i_data,
    output t_quad o_data
);

    t_quad r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== src/stk_lane.sv =====
// Datapath of one channel: mapping, running sum, reciprocal divide,
// clamp and center snap. Depends on stk_pkg.
module stk_lane import stk_pkg::*; #(
    parameter int WINDOW_LENGTH = DEFAULT_WINDOW_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_ctl           i_ctl,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic [MAP_W-1:0]    i_oldest,
    input  logic [VALUE_W-1:0]  i_band_lo,
    input  logic [VALUE_W-1:0]  i_band_hi,
    output logic [MAP_W-1:0]    o_mapped,
    output logic [VALUE_W-1:0]  o_value
);

    localparam int SUM_W  = MAP_W + $clog2(WINDOW_LENGTH);
    localparam int LOG_W  = $clog2(WINDOW_LENGTH);
    localparam int SHIFT  = SUM_W + LOG_W;
    localparam int PROD_W = 2 * SUM_W + 1;
    // ceil(2^SHIFT / N): exact quotient for every SUM_W-bit dividend
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

    logic [MAP_W+1:0]   w_map_full;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [PROD_W-1:0]  r_prod;
    logic [MAP_W-1:0]   w_quot;
    logic [MAP_W-1:0]   w_clamp;
    logic [VALUE_W-1:0] w_final;
    logic [VALUE_W-1:0] r_value;

    // 1000 + sample/4 - offset; always 489..2535
    assign w_map_full = (MAP_W+2)'(MAP_BASE)
                      + (MAP_W+2)'(i_sample[SAMPLE_W-1:2])
                      - {{(MAP_W+2-OFFSET_W){i_offset[OFFSET_W-1]}}, i_offset};
    assign o_mapped = w_map_full[MAP_W-1:0];

    assign n_sum = r_sum - SUM_W'(i_oldest) + SUM_W'(o_mapped);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.load_sum) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP);
        end
    end

    assign w_quot = r_prod[SHIFT +: MAP_W];

    always_comb begin
        priority if (w_quot < MAP_W'(OUT_LOW)) begin
            w_clamp = MAP_W'(OUT_LOW);
        end else if (w_quot > MAP_W'(OUT_HIGH)) begin
            w_clamp = MAP_W'(OUT_HIGH);
        end else begin
            w_clamp = w_quot;
        end
        if (w_clamp > MAP_W'(i_band_lo) && w_clamp < MAP_W'(i_band_hi)) begin
            w_final = CENTER;
        end else begin
            w_final = w_clamp[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_value <= w_final;
        end
    end

    assign o_value = r_value;

endmodule

// ===== src/stk_chk.sv =====
// Port-level checker for the stick channel conditioner, bound to the top.
// Depends on stk_pkg and stick_channel_conditioner.
module stk_chk import stk_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [VALUE_W-1:0] o_throttle_value,
    input logic [VALUE_W-1:0] o_pitch_value,
    input logic [VALUE_W-1:0] o_roll_value,
    input logic [VALUE_W-1:0] o_yaw_value
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_throttle_value) && $stable(o_pitch_value)
            && $stable(o_roll_value) && $stable(o_yaw_value))
        else $error("result beat changed while stalled");

    // input backs up only behind a stalled, full output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // clamp range on every channel
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_throttle_value >= OUT_LOW && o_throttle_value <= OUT_HIGH
            && o_pitch_value >= OUT_LOW && o_pitch_value <= OUT_HIGH
            && o_roll_value  >= OUT_LOW && o_roll_value  <= OUT_HIGH
            && o_yaw_value   >= OUT_LOW && o_yaw_value   <= OUT_HIGH)
        else $error("channel value outside clamp range");

    // center band snaps to center
    a_deadband: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            !(o_throttle_value > THR_BAND_LOW && o_throttle_value < THR_BAND_HIGH
              && o_throttle_value != CENTER)
            && !(o_pitch_value > AXIS_BAND_LOW && o_pitch_value < AXIS_BAND_HIGH
              && o_pitch_value != CENTER)
            && !(o_roll_value > AXIS_BAND_LOW && o_roll_value < AXIS_BAND_HIGH
              && o_roll_value != CENTER)
            && !(o_yaw_value > AXIS_BAND_LOW && o_yaw_value < AXIS_BAND_HIGH
              && o_yaw_value != CENTER))
        else $error("value inside center band not snapped");

endmodule

bind stick_channel_conditioner stk_chk u_stk_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_throttle_value (o_throttle_value),
    .o_pitch_value    (o_pitch_value),
    .o_roll_value     (o_roll_value),
    .o_yaw_value      (o_yaw_value)
);
